FILE: design/dnsq_pkg.sv
// ----------------------------------------------------------------------------
// dnsq_pkg: shared types and constants for the DNS question name extractor
// Holds the message word type passed between the input stage and the parser,
// and the fixed character and header constants.
// ----------------------------------------------------------------------------
package dnsq_pkg;

  // fixed message layout
  localparam int unsigned HeaderBytes = 12;
  localparam logic [3:0]  HeaderLast  = 4'(HeaderBytes - 1);
  localparam logic [3:0]  PosCountHi  = 4'd4;
  localparam logic [3:0]  PosCountLo  = 4'd5;
  localparam logic [1:0]  TailBytesM1 = 2'd3;

  // characters given as results, and the null length byte that ends a name
  localparam logic [7:0]  CharDot  = 8'h2E;
  localparam logic [7:0]  CharNl   = 8'h0A;
  localparam logic [7:0]  CharNull = 8'h00;

  // one message word held in the input stage
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last_byte;
  } msg_word_t;

endpackage

FILE: design/dnsq_msg_if.sv
// ----------------------------------------------------------------------------
// dnsq_msg_if: message byte channel
// Valid/ready channel carrying one DNS message byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface dnsq_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       last_byte;

  modport source (output valid, output msg_byte, output last_byte, input ready);
  modport sink   (input valid, input msg_byte, input last_byte, output ready);
endinterface

FILE: design/dnsq_name_if.sv
// ----------------------------------------------------------------------------
// dnsq_name_if: name character channel
// Valid/ready channel carrying one name character and the end-of-name flag.
// ----------------------------------------------------------------------------
interface dnsq_name_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       name_done;

  modport source (output valid, output out_char, output name_done, input ready);
  modport sink   (input valid, input out_char, input name_done, output ready);
endinterface

FILE: design/dnsq_in_stage.sv
// ----------------------------------------------------------------------------
// dnsq_in_stage: input register
// Registers one message word; refills in the same cycle it is consumed.
// ----------------------------------------------------------------------------
module dnsq_in_stage
  import dnsq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  msg_word_t word_i,
  output logic      valid_o,
  input  logic      take_i,
  output msg_word_t word_o
);

  logic      valid_q;
  msg_word_t word_q;

  // free when empty or being drained this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_i;
    end
  end

endmodule

FILE: design/dnsq_parser.sv
// ----------------------------------------------------------------------------
// dnsq_parser: question name parser and result register
// Steps the parse state by one word and registers the character it gives.
// ----------------------------------------------------------------------------
module dnsq_parser
  import dnsq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  msg_word_t  word_i,
  output logic       take_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] out_char_o,
  output logic       name_done_o
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN    = 3'd1,
    PH_LABEL  = 3'd2,
    PH_TAIL   = 3'd3,
    PH_IDLE   = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  header_pos_q, header_pos_d;
  logic [7:0]  count_high_q, count_high_d;
  logic [15:0] questions_left_q, questions_left_d;
  logic [7:0]  label_left_q, label_left_d;
  logic        first_label_q, first_label_d;
  logic [1:0]  tail_left_q, tail_left_d;
  logic        out_valid_q;
  logic [7:0]  out_char_q, out_char_d;
  logic        name_done_q, name_done_d;
  logic        emit;
  logic [7:0]  b;
  logic [7:0]  label_dec;

  // consume a word when the result register is free or draining
  assign take_o = valid_i && (!out_valid_q || ready_i);
  assign b      = word_i.msg_byte;
  assign label_dec = label_left_q - 8'd1;

  // next parse state for the held word
  always_comb begin
    phase_d          = phase_q;
    header_pos_d     = header_pos_q;
    count_high_d     = count_high_q;
    questions_left_d = questions_left_q;
    label_left_d     = label_left_q;
    first_label_d    = first_label_q;
    tail_left_d      = tail_left_q;
    emit             = 1'b0;
    out_char_d       = b;
    name_done_d      = 1'b0;
    unique case (phase_q)
      PH_HEADER: begin
        if (header_pos_q == PosCountHi) begin
          count_high_d = b;
        end else if (header_pos_q == PosCountLo) begin
          questions_left_d = {count_high_q, b};
        end
        if (header_pos_q >= HeaderLast) begin
          header_pos_d  = 4'd0;
          first_label_d = 1'b1;
          phase_d       = (questions_left_d != 16'd0) ? PH_LEN : PH_IDLE;
        end else begin
          header_pos_d = header_pos_q + 4'd1;
        end
      end
      PH_LEN: begin
        if (b == CharNull) begin
          emit             = 1'b1;
          out_char_d       = CharNl;
          name_done_d      = 1'b1;
          questions_left_d = questions_left_q - 16'd1;
          first_label_d    = 1'b1;
          tail_left_d      = TailBytesM1;
          phase_d          = PH_TAIL;
        end else begin
          if (!first_label_q) begin
            emit       = 1'b1;
            out_char_d = CharDot;
          end
          first_label_d = 1'b0;
          label_left_d  = b;
          phase_d       = PH_LABEL;
        end
      end
      PH_LABEL: begin
        emit         = 1'b1;
        label_left_d = label_dec;
        if (label_dec == 8'd0) begin
          phase_d = PH_LEN;
        end
      end
      PH_TAIL: begin
        if (tail_left_q == 2'd0) begin
          phase_d = (questions_left_q != 16'd0) ? PH_LEN : PH_IDLE;
        end else begin
          tail_left_d = tail_left_q - 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // parse state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_HEADER;
      header_pos_q     <= 4'd0;
      count_high_q     <= 8'd0;
      questions_left_q <= 16'd0;
      label_left_q     <= 8'd0;
      first_label_q    <= 1'b1;
      tail_left_q      <= 2'd0;
      out_valid_q      <= 1'b0;
      out_char_q       <= 8'd0;
      name_done_q      <= 1'b0;
    end else begin
      if (take_o) begin
        out_valid_q <= emit;
        if (emit) begin
          out_char_q  <= out_char_d;
          name_done_q <= name_done_d;
        end
        if (word_i.last_byte) begin
          phase_q          <= PH_HEADER;
          header_pos_q     <= 4'd0;
          count_high_q     <= 8'd0;
          questions_left_q <= 16'd0;
          label_left_q     <= 8'd0;
          first_label_q    <= 1'b1;
          tail_left_q      <= 2'd0;
        end else begin
          phase_q          <= phase_d;
          header_pos_q     <= header_pos_d;
          count_high_q     <= count_high_d;
          questions_left_q <= questions_left_d;
          label_left_q     <= label_left_d;
          first_label_q    <= first_label_d;
          tail_left_q      <= tail_left_d;
        end
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign valid_o     = out_valid_q;
  assign out_char_o  = out_char_q;
  assign name_done_o = name_done_q;

endmodule

FILE: design/dns_question_name_extractor_top.sv
// ----------------------------------------------------------------------------
// dns_question_name_extractor_top: DNS question name extractor
// Streams the question names of a DNS message out as text characters.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one message byte per word, header first, with last_byte
//   set on the final byte. The 12-byte header is skipped and the question
//   count taken from header bytes 4 and 5. out_o gives, per question, the
//   label characters, a dot between labels and a newline with name_done
//   set at the end of each name. Type and class bytes give nothing, nor do
//   bytes after the last question. Compression pointers are read as plain
//   label lengths.
//   A result is registered: its byte passes the input register and then
//   the result register, which holds it until out_o takes it. One byte is
//   accepted per cycle while the receiver does not stall, set by the parse
//   step between the two registers.
//   A word flagged last_byte returns the parser to the header state after
//   its own result. Reset empties both registers and clears the parse state.
//   When the receiver stalls the result register holds its word, the input
//   register holds at most one more byte, and then in_i.ready drops.
// ----------------------------------------------------------------------------
module dns_question_name_extractor_top
  import dnsq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  dnsq_msg_if.sink    in_i,
  dnsq_name_if.source out_o
);

  msg_word_t in_word;
  msg_word_t held_word;
  logic      held_valid;
  logic      take;

  assign in_word.msg_byte  = in_i.msg_byte;
  assign in_word.last_byte = in_i.last_byte;

  // input register
  dnsq_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .word_i  (in_word),
    .valid_o (held_valid),
    .take_i  (take),
    .word_o  (held_word)
  );

  // parser and result register
  dnsq_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (held_valid),
    .word_i      (held_word),
    .take_o      (take),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .out_char_o  (out_o.out_char),
    .name_done_o (out_o.name_done)
  );

endmodule
